/* rtl/lrupr_pkg.sv */
// Shared types and constants for the LRU page replacement block.
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

  localparam int CFG_W          = 5;
  localparam int CFG_RESET      = 16;
  localparam int FRAME_USED_W   = 4;
  localparam int FAULT_W        = 32;
  localparam int OUT_FIELDS_W   = 1 + FRAME_USED_W + FAULT_W + 1;
  localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT_SCAN,
    ST_UPDATE,
    ST_MIN_SCAN,
    ST_FINISH
  } lrupr_state_t;

endpackage

`default_nettype wire

/* rtl/lrupr_cmp_unit.sv */
// Shared comparator used for both the page match and the stamp minimum search.
`timescale 1ns / 1ps
`default_nettype none

module lrupr_cmp_unit #(
  parameter int CMP_W = 32
) (
  input  logic [CMP_W-1:0] a,
  input  logic [CMP_W-1:0] b,
  output logic             eq,
  output logic             lt
);

  assign eq = (a == b);
  assign lt = (a < b);

endmodule

`default_nettype wire

/* rtl/lrupr_frame_store.sv */
// Frame table: page and stamp memories with per-frame valid flags.
`timescale 1ns / 1ps
`default_nettype none

module lrupr_frame_store #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  parameter int STAMP_BITS = 32,
  parameter int FIDX_W     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [FIDX_W-1:0]     rd_addr,
  output logic [PAGE_BITS-1:0]  rd_page,
  output logic [STAMP_BITS-1:0] rd_stamp,
  output logic                  rd_valid,
  input  logic                  wr_en,
  input  logic                  wr_page_en,
  input  logic [FIDX_W-1:0]     wr_addr,
  input  logic [PAGE_BITS-1:0]  wr_page,
  input  logic [STAMP_BITS-1:0] wr_stamp
);

  logic [PAGE_BITS-1:0]  page_mem  [MAX_FRAMES];
  logic [STAMP_BITS-1:0] stamp_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
      if (wr_page_en) begin
        page_mem[wr_addr] <= wr_page;
      end
    end
    rd_page  <= page_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/lru_page_replacement.sv */
// Top level of the LRU page replacement block: sequencer, counters and stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Each item on the slave stream is one page reference. The block looks the page up
// in the active frames and, on a miss, loads it into the least recently used frame.
// One result item per reference leaves on the master stream with the hit flag, the
// frame now holding the page, the saturating fault count and the stamp-exhausted flag.
//
// An item walks through two scans of the frame table, one frame per cycle through a
// single registered memory read port and one shared comparator: a match scan, a
// one-cycle update, then a minimum-stamp scan that picks the next victim. The block
// takes one item at a time and s_tready is high only while it is idle.
//
// The result sits in an output register, so the next item can be accepted while a
// result waits for m_tready; a stalled receiver only holds the block once the next
// result is finished. The frame count register is written on its own channel and
// should only be changed while the block is idle. Reset clears all valid flags,
// the stamp and fault counters, the victim pointer and sets the frame count to 16.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration: frames_in_use.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_W-1:0]                   cfg_data,
  // Input stream. s_tdata: page_number, zero padded to whole bytes.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0]     s_tdata,
  // Output stream. m_tdata from bit 0: hit, frame_used[3:0], fault_count[31:0],
  // stamp_exhausted, zero padding.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [OUT_TDATA_W-1:0]             m_tdata
);

  localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (PAGE_BITS > STAMP_BITS) ? PAGE_BITS : STAMP_BITS;

  lrupr_state_t state, state_next;

  logic [CFG_W-1:0]      frames_in_use;
  logic [CNT_W-1:0]      active_n;
  logic [CNT_W-1:0]      n_reg;
  logic [PAGE_BITS-1:0]  page_reg;
  logic [CNT_W-1:0]      rd_idx;
  logic                  pipe_vld;
  logic [FIDX_W-1:0]     pipe_idx;
  logic                  found;
  logic [FIDX_W-1:0]     hit_idx;
  logic [FIDX_W-1:0]     victim;
  logic [FIDX_W-1:0]     used;
  logic [STAMP_BITS-1:0] least;
  logic [FIDX_W-1:0]     pick;
  logic [STAMP_BITS-1:0] stamp_counter;
  logic [STAMP_BITS-1:0] stamp_counter_next;
  logic [FAULT_W-1:0]    faults;

  logic                  res_hit;
  logic [FIDX_W-1:0]     res_used;

  logic [PAGE_BITS-1:0]  rd_page;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  rd_valid;
  logic [STAMP_BITS-1:0] rd_stamp_eff;

  logic [CMP_W-1:0]      cmp_a;
  logic [CMP_W-1:0]      cmp_b;
  logic                  cmp_eq;
  logic                  cmp_lt;

  logic                  accept;
  logic                  scan_state;
  logic                  issue;
  logic                  scan_done;
  logic                  do_update;
  logic                  load_out;

  // ---------------------------------------------------------------------------
  // Frame count register and the clamped active count.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_W'(CFG_RESET);
    end else if (cfg_valid) begin
      frames_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      active_n = CNT_W'(1);
    end else if (int'(frames_in_use) > MAX_FRAMES) begin
      active_n = CNT_W'(MAX_FRAMES);
    end else begin
      active_n = CNT_W'(frames_in_use);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign accept     = s_tvalid && s_tready;
  assign scan_state = (state == ST_HIT_SCAN) || (state == ST_MIN_SCAN);
  assign issue      = scan_state && (rd_idx < n_reg);
  assign scan_done  = scan_state && !issue && !pipe_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    do_update  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_HIT_SCAN;
        end
      end
      ST_HIT_SCAN: begin
        if (scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        do_update  = 1'b1;
        state_next = ST_MIN_SCAN;
      end
      ST_MIN_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame table and the shared comparator.
  // ---------------------------------------------------------------------------
  // A frame that was never written reads with stamp zero.
  assign rd_stamp_eff = rd_valid ? rd_stamp : '0;

  // Victim falls back to frame 0 when it lies outside the active frames.
  assign used = found ? hit_idx : ((CNT_W'(victim) < n_reg) ? victim : '0);

  assign stamp_counter_next = (stamp_counter != '1) ? stamp_counter + 1'b1 : stamp_counter;

  lrupr_frame_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .STAMP_BITS (STAMP_BITS),
    .FIDX_W     (FIDX_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_addr    (rd_idx[FIDX_W-1:0]),
    .rd_page    (rd_page),
    .rd_stamp   (rd_stamp),
    .rd_valid   (rd_valid),
    .wr_en      (do_update),
    .wr_page_en (!found),
    .wr_addr    (used),
    .wr_page    (page_reg),
    .wr_stamp   (stamp_counter_next)
  );

  always_comb begin
    if (state == ST_HIT_SCAN) begin
      cmp_a = CMP_W'(rd_page);
      cmp_b = CMP_W'(page_reg);
    end else begin
      cmp_a = CMP_W'(rd_stamp_eff);
      cmp_b = CMP_W'(least);
    end
  end

  lrupr_cmp_unit #(
    .CMP_W (CMP_W)
  ) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .eq (cmp_eq),
    .lt (cmp_lt)
  );

  // ---------------------------------------------------------------------------
  // Scan datapath: the compare works on the frame addressed in the cycle before.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
      rd_idx   <= '0;
    end else begin
      pipe_vld <= issue;
      if (accept || do_update) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pipe_idx <= rd_idx[FIDX_W-1:0];
    end
    if (accept) begin
      page_reg <= s_tdata[PAGE_BITS-1:0];
      n_reg    <= active_n;
    end
    if (state == ST_HIT_SCAN && pipe_vld && rd_valid && cmp_eq && !found) begin
      hit_idx <= pipe_idx;
    end
    if (state == ST_MIN_SCAN && pipe_vld && (pipe_idx == '0 || cmp_lt)) begin
      least <= rd_stamp_eff;
      pick  <= pipe_idx;
    end
    if (do_update) begin
      res_hit  <= found;
      res_used <= used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found         <= 1'b0;
      victim        <= '0;
      stamp_counter <= '0;
      faults        <= '0;
    end else begin
      if (accept) begin
        found <= 1'b0;
      end else if (state == ST_HIT_SCAN && pipe_vld && rd_valid && cmp_eq) begin
        found <= 1'b1;
      end
      if (do_update) begin
        stamp_counter <= stamp_counter_next;
        if (!found && faults != '1) begin
          faults <= faults + 1'b1;
        end
      end
      if (state == ST_MIN_SCAN && scan_done) begin
        victim <= pick;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OUT_TDATA_W'({(stamp_counter == '1), faults,
                               FRAME_USED_W'(res_used), res_hit});
    end
  end

endmodule

`default_nettype wire

/* verif/lru_replacement_checker.sv */
// Checker for the LRU page replacement block: watches all channels, predicts and compares.
`timescale 1ns / 1ps

module lru_replacement_checker
  import lrupr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [15:0]            s_tdata,     // page_number
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // From bit 0: hit, frame_used[3:0], fault_count[31:0], stamp_exhausted, padding.
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     errors,
  output int                     pending
);

  localparam int FRAMES = 16;

  typedef struct packed {
    bit        hit;
    bit [3:0]  frame;
    bit [31:0] faults;
    bit        exhausted;
  } lru_result_t;

  // Shadow copy of the frame table and counters.
  bit [CFG_W-1:0] frames_cfg;
  bit [15:0]      page_tag [FRAMES];
  bit             resident [FRAMES];
  bit [31:0]      last_use [FRAMES];
  bit [31:0]      use_clock;
  bit [3:0]       victim;
  bit [31:0]      fault_total;

  lru_result_t    lookup_results [$];
  int             error_count;

  assign errors = error_count;

  // One page reference: hit search, load on a miss, then choose the next victim.
  function automatic lru_result_t reference_page(input bit [15:0] page);
    int          n;
    int          i;
    int          pick;
    bit          found;
    bit [3:0]    slot;
    bit [31:0]   least;
    lru_result_t r;
    n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    found = 1'b0;
    slot = '0;
    for (i = 0; i < n; i++) begin
      if (!found && resident[i] && page_tag[i] == page) begin
        found = 1'b1;
        slot = 4'(i);
      end
    end
    if (!found) begin
      if (fault_total != '1) fault_total++;
      slot = (int'(victim) < n) ? victim : 4'd0;
      page_tag[slot] = page;
      resident[slot] = 1'b1;
    end
    if (use_clock != '1) use_clock++;
    last_use[slot] = use_clock;
    least = last_use[0];
    pick = 0;
    for (i = 1; i < n; i++) begin
      if (last_use[i] < least) begin
        least = last_use[i];
        pick = i;
      end
    end
    victim = 4'(pick);
    r.hit = found;
    r.frame = slot;
    r.faults = fault_total;
    r.exhausted = (use_clock == '1);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lru_result_t want;
    lru_result_t got;
    if (rst) begin
      frames_cfg = CFG_W'(CFG_RESET);
      for (int i = 0; i < FRAMES; i++) begin
        page_tag[i] = '0;
        resident[i] = 1'b0;
        last_use[i] = '0;
      end
      use_clock = '0;
      victim = '0;
      fault_total = '0;
      lookup_results.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) frames_cfg = cfg_data;
      if (s_tvalid && s_tready) lookup_results.push_back(reference_page(s_tdata));
      if (m_tvalid && m_tready) begin
        got.hit = m_tdata[0];
        got.frame = m_tdata[4:1];
        got.faults = m_tdata[36:5];
        got.exhausted = m_tdata[37];
        if (lookup_results.size() == 0) begin
          if (error_count < 10)
            $display("%0t: result with nothing expected: hit=%0b frame=%0d faults=%0d exh=%0b",
                     $realtime, got.hit, got.frame, got.faults, got.exhausted);
          error_count++;
        end else begin
          want = lookup_results.pop_front();
          if (want.hit != got.hit || want.frame != got.frame ||
              want.faults != got.faults || want.exhausted != got.exhausted) begin
            if (error_count < 10)
              $display("%0t: mismatch: expected hit=%0b frame=%0d faults=%0d exh=%0b, %s%0b %0d %0d %0b",
                       $realtime, want.hit, want.frame, want.faults, want.exhausted,
                       "got ", got.hit, got.frame, got.faults, got.exhausted);
            error_count++;
          end
        end
      end
      pending <= lookup_results.size();
    end
  end

endmodule

/* verif/tb_lru_page_replacement.sv */
// Testbench top for the LRU page replacement block: stimulus, pacing and verdict.
`timescale 1ns / 1ps

// The stimulus runs in two parts. A directed part at the reset frame count fills
// frames in order, hits the extreme page numbers, shrinks the frame count so the
// pending victim falls outside the active frames, writes the out-of-range counts
// 0 and 31 and 17, and checks that inactive frames keep their pages. A random part
// then walks through a list of frame counts; within each setting most references
// come from a small working set sized around the frame count, so hits, refreshes
// and evictions all happen often, and the rest are arbitrary 16-bit pages.
//
// The checker beside the block predicts every result and counts failures. This
// module only drives the channels and reports the verdict.
module tb_lru_page_replacement
  import lrupr_pkg::*;
();

  localparam int LIMIT = 1000000;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;     // page_number
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // From bit 0: hit, frame_used[3:0], fault_count[31:0], stamp_exhausted, padding.
  logic [OUT_TDATA_W-1:0] m_tdata;

  int errors;
  int pending;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;    // when set, neither side inserts idle cycles

  lru_page_replacement u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  lru_replacement_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog. The slowest correct run is far below this limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_lru_page_replacement: done, errors");
      $finish;
    end
  end

  // Receiver pacing: mostly single-cycle stalls at random, now and then a long
  // one so that the block finishes a second item behind a held result.
  always @(posedge clk) begin : rx_pace
    int roll;
    roll = $urandom_range(0, 99);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      if ($urandom_range(0, 999) == 0) stall_left <= $urandom_range(20, 60);
      m_tready <= (roll >= 26);
    end
  end

  // Offers one page reference and returns at the edge where it is taken. The
  // valid is left high so that back-to-back items need no extra edge.
  task automatic push_page(input bit [15:0] page);
    if (!calm && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= page;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Frame count writes happen only with the block idle.
  task automatic set_frames(input bit [CFG_W-1:0] count);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pages from the current working set, sometimes any page at all.
  function automatic bit [15:0] next_page(input bit [15:0] base, input int span);
    if ($urandom_range(0, 99) < 15) return 16'($urandom);
    return base + 16'($urandom_range(0, span - 1));
  endfunction

  initial begin : stimulus
    bit [CFG_W-1:0] plan [12];
    bit [15:0]      base;
    int             n;
    int             span;

    plan = '{5'd1, 5'd2, 5'd4, 5'd16, 5'd7, 5'd0, 5'd12, 5'd31, 5'd3, 5'd16, 5'd9, 5'd17};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset count of 16: frames fill in order, then two hits and one more load.
    push_page(16'h0000);
    push_page(16'hFFFF);
    push_page(16'h1234);
    push_page(16'hA5A5);
    push_page(16'h5A5A);
    push_page(16'h0000);
    push_page(16'hFFFF);
    push_page(16'h0007);

    // The victim is now the first empty frame, beyond three active frames, so
    // the next miss must go to frame 0.
    set_frames(5'd3);
    push_page(16'h0101);
    push_page(16'h1234);
    push_page(16'h5A5A);

    // A count of zero behaves as a single frame.
    set_frames(5'd0);
    push_page(16'h00FF);
    push_page(16'h00FF);
    push_page(16'h0101);

    // Counts above 16 behave as 16; pages left in the inactive frames are hits.
    set_frames(5'd31);
    push_page(16'h0007);
    push_page(16'hA5A5);
    push_page(16'h8000);
    set_frames(5'd17);
    push_page(16'h8000);
    push_page(16'h0001);

    // Random part: about 80 references per frame count.
    foreach (plan[p]) begin
      set_frames(plan[p]);
      calm = (p == 3);
      n = (plan[p] == 0) ? 1 : (plan[p] > 16) ? 16 : int'(plan[p]);
      base = 16'($urandom);
      case ($urandom_range(0, 3))
        0:       span = n;
        1:       span = n + 1;
        2:       span = 2 * n;
        default: span = (n > 1) ? n - 1 : 1;
      endcase
      for (int k = 0; k < 80; k++) begin
        // Hold off in the middle of one phase until the block has caught up.
        if (p == 6 && k == 40) drain();
        if ($urandom_range(0, 99) < 5) base = 16'($urandom);
        push_page(next_page(base, span));
      end
    end
    calm = 1'b0;

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb_lru_page_replacement: done, clean");
    end else begin
      $display("tb_lru_page_replacement: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lrupr_pkg.sv
rtl/lrupr_cmp_unit.sv
rtl/lrupr_frame_store.sv
rtl/lru_page_replacement.sv
verif/lru_replacement_checker.sv
verif/tb_lru_page_replacement.sv
